### sv/qvr_pkg.sv
// Package for the quaternion vector rotate unit: widths, types,
// register indexes and the conjugate-product selection tables.
// No dependencies.
package qvr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 14;
  localparam int QUAT_WIDTH  = 16;
  localparam int SHIFT_BITS  = 2 * FRAC_BITS;
  localparam int CFG_IDX_W   = 4;

  localparam int VPROD_W   = QUAT_WIDTH + COORD_WIDTH;
  localparam int P_W       = VPROD_W + 2;
  localparam int P_LO_W    = P_W / 2;
  localparam int P_HI_W    = P_W - P_LO_W;
  localparam int PART_LO_W = P_LO_W + 1 + QUAT_WIDTH;
  localparam int PART_HI_W = P_HI_W + QUAT_WIDTH;
  localparam int TERM_W    = P_W + QUAT_WIDTH;
  localparam int SUM_W     = TERM_W + 3;
  localparam int SHV_W     = SUM_W - SHIFT_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [QUAT_WIDTH-1:0]  qcomp_t;
  typedef logic signed [VPROD_W-1:0]     vprod_t;
  typedef logic signed [P_W-1:0]         pval_t;
  typedef logic signed [PART_LO_W-1:0]   part_lo_t;
  typedef logic signed [PART_HI_W-1:0]   part_hi_t;
  typedef logic signed [TERM_W-1:0]      term_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [SHV_W-1:0]       shv_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
  typedef logic [1:0]                    qidx_t;

  typedef struct packed {
    qcomp_t x;
    qcomp_t y;
    qcomp_t z;
    qcomp_t w;
  } quat_t;

  typedef struct packed {
    pval_t w;
    pval_t x;
    pval_t y;
    pval_t z;
  } pquad_t;

  localparam cfg_idx_t REG_ROT_X = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ROT_Y = cfg_idx_t'(1);
  localparam cfg_idx_t REG_ROT_Z = cfg_idx_t'(2);
  localparam cfg_idx_t REG_ROT_W = cfg_idx_t'(3);

  localparam qcomp_t ROT_W_RESET = qcomp_t'(1 << FRAC_BITS);

  localparam qidx_t Q_IDX_X = 2'd0;
  localparam qidx_t Q_IDX_Y = 2'd1;
  localparam qidx_t Q_IDX_Z = 2'd2;
  localparam qidx_t Q_IDX_W = 2'd3;

  // q component paired with p.w, p.x, p.y, p.z for each output axis
  localparam qidx_t Q_SEL [0:2][0:3] = '{
    '{Q_IDX_X, Q_IDX_W, Q_IDX_Z, Q_IDX_Y},
    '{Q_IDX_Y, Q_IDX_Z, Q_IDX_W, Q_IDX_X},
    '{Q_IDX_Z, Q_IDX_Y, Q_IDX_X, Q_IDX_W}
  };
  // set where the term is subtracted
  localparam logic [0:3] T_NEG [0:2] = '{4'b1010, 4'b1001, 4'b1100};

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam sum_t   ROUND_HALF = sum_t'(1) << (SHIFT_BITS - 1);

  function automatic vprod_t mul_qv(qcomp_t a, coord_t b);
    return vprod_t'(a) * vprod_t'(b);
  endfunction

endpackage

### sv/quaternion_vector_rotate_unit.sv
// Quaternion vector rotate unit, top level: config registers and the
// six-stage rotation pipeline. Uses qvr_pkg, qvr_vec_mul, qvr_conj_mul,
// qvr_round_sat.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   point_x, point_y, point_z
//   out      out_valid/out_stall out_x, out_y, out_z, saturated
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat per cycle while out_stall is low.
// Stages: q*v products, p sums, split p*q products, product assembly,
// signed sum, round/saturate. Each stage holds under stall and takes new
// data when empty, so bubbles close up. rst is synchronous and clears the
// valid bits and sets q to identity. cfg_ready is always high.
module quaternion_vector_rotate_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [qvr_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [qvr_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [qvr_pkg::COORD_WIDTH-1:0] point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qvr_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [qvr_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [qvr_pkg::COORD_WIDTH-1:0] out_z,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] cfg_data
);
  import qvr_pkg::*;

  quat_t  rot;
  logic   vm_ready, vm_valid;
  logic   cm_ready, cm_valid;
  logic   rs_ready;
  pquad_t pq;
  sum_t   sums [3];
  coord_t res [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.x <= '0;
      rot.y <= '0;
      rot.z <= '0;
      rot.w <= ROT_W_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROT_X: rot.x <= cfg_data;
        REG_ROT_Y: rot.y <= cfg_data;
        REG_ROT_Z: rot.z <= cfg_data;
        REG_ROT_W: rot.w <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !vm_ready;

  qvr_vec_mul u_vec_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (vm_ready),
    .q         (rot),
    .vx        (point_x),
    .vy        (point_y),
    .vz        (point_z),
    .out_valid (vm_valid),
    .out_ready (cm_ready),
    .p         (pq)
  );

  qvr_conj_mul u_conj_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vm_valid),
    .in_ready  (cm_ready),
    .q         (rot),
    .p         (pq),
    .out_valid (cm_valid),
    .out_ready (rs_ready),
    .sum       (sums)
  );

  qvr_round_sat u_round_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cm_valid),
    .in_ready  (rs_ready),
    .sum       (sums),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .res       (res),
    .sat       (saturated)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];

endmodule

### sv/qvr_vec_mul.sv
// First half of the rotation: p = q * (v,0), two register stages.
// Stage 1 forms twelve q*v products, stage 2 sums them. Uses qvr_pkg.
module qvr_vec_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qvr_pkg::quat_t  q,
  input  qvr_pkg::coord_t vx,
  input  qvr_pkg::coord_t vy,
  input  qvr_pkg::coord_t vz,
  output logic            out_valid,
  input  logic            out_ready,
  output qvr_pkg::pquad_t p
);
  import qvr_pkg::*;

  logic   v1;
  logic   en1, en2;
  vprod_t a_xx, a_yy, a_zz, a_wx, a_yz, a_zy;
  vprod_t a_wy, a_xz, a_zx, a_wz, a_xy, a_yx;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      a_xx <= mul_qv(q.x, vx);
      a_yy <= mul_qv(q.y, vy);
      a_zz <= mul_qv(q.z, vz);
      a_wx <= mul_qv(q.w, vx);
      a_yz <= mul_qv(q.y, vz);
      a_zy <= mul_qv(q.z, vy);
      a_wy <= mul_qv(q.w, vy);
      a_xz <= mul_qv(q.x, vz);
      a_zx <= mul_qv(q.z, vx);
      a_wz <= mul_qv(q.w, vz);
      a_xy <= mul_qv(q.x, vy);
      a_yx <= mul_qv(q.y, vx);
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      p.w <= pval_t'(0) - pval_t'(a_xx) - pval_t'(a_yy) - pval_t'(a_zz);
      p.x <= pval_t'(a_wx) + pval_t'(a_yz) - pval_t'(a_zy);
      p.y <= pval_t'(a_wy) - pval_t'(a_xz) + pval_t'(a_zx);
      p.z <= pval_t'(a_wz) + pval_t'(a_xy) - pval_t'(a_yx);
    end
  end

endmodule

### sv/qvr_conj_mul.sv
// Second half of the rotation: vector part of p * conj(q), three stages.
// Split partial products, product assembly, signed sum with rounding bias.
// Uses qvr_pkg.
module qvr_conj_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qvr_pkg::quat_t  q,
  input  qvr_pkg::pquad_t p,
  output logic            out_valid,
  input  logic            out_ready,
  output qvr_pkg::sum_t   sum [3]
);
  import qvr_pkg::*;

  logic     v3, v4;
  logic     en3, en4, en5;
  qcomp_t   qa [4];
  pval_t    pa [4];
  part_lo_t plo [3][4];
  part_hi_t phi [3][4];
  term_t    term [3][4];

  assign qa[Q_IDX_X] = q.x;
  assign qa[Q_IDX_Y] = q.y;
  assign qa[Q_IDX_Z] = q.z;
  assign qa[Q_IDX_W] = q.w;
  assign pa[0] = p.w;
  assign pa[1] = p.x;
  assign pa[2] = p.y;
  assign pa[3] = p.z;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // p split in halves keeps each multiplier narrow
  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          plo[i][j] <= part_lo_t'($signed({1'b0, pa[j][P_LO_W-1:0]}))
                       * part_lo_t'(qa[Q_SEL[i][j]]);
          phi[i][j] <= part_hi_t'($signed(pa[j][P_W-1:P_LO_W]))
                       * part_hi_t'(qa[Q_SEL[i][j]]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          term[i][j] <= (term_t'(phi[i][j]) <<< P_LO_W) + term_t'(plo[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= ROUND_HALF
                  + (T_NEG[i][0] ? -sum_t'(term[i][0]) : sum_t'(term[i][0]))
                  + (T_NEG[i][1] ? -sum_t'(term[i][1]) : sum_t'(term[i][1]))
                  + (T_NEG[i][2] ? -sum_t'(term[i][2]) : sum_t'(term[i][2]))
                  + (T_NEG[i][3] ? -sum_t'(term[i][3]) : sum_t'(term[i][3]));
      end
    end
  end

endmodule

### sv/qvr_round_sat.sv
// Output stage: arithmetic shift of the biased sums, per-axis saturation,
// result register. Uses qvr_pkg.
module qvr_round_sat (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qvr_pkg::sum_t   sum [3],
  output logic            out_valid,
  input  logic            out_ready,
  output qvr_pkg::coord_t res [3],
  output logic            sat
);
  import qvr_pkg::*;

  logic   en;
  shv_t   shv [3];
  coord_t clip_val [3];
  logic   [2:0] clip;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shv[i] = $signed(sum[i][SUM_W-1:SHIFT_BITS]);
      if (shv[i] > shv_t'(COORD_MAX)) begin
        clip_val[i] = COORD_MAX;
        clip[i]     = 1'b1;
      end else if (shv[i] < shv_t'(COORD_MIN)) begin
        clip_val[i] = COORD_MIN;
        clip[i]     = 1'b1;
      end else begin
        clip_val[i] = shv[i][COORD_WIDTH-1:0];
        clip[i]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      res <= clip_val;
      sat <= |clip;
    end
  end

endmodule
